@@ rtl/mebp_pkg.sv @@
// Package for the escape-time pixel unit: sequencer states, colour channel
// select codes, register indexes and fixed-point constants.
// No dependencies.
package mebp_pkg;

   localparam int COORD_W  = 32;
   localparam int FRAC_W   = 26;
   localparam int Z_W      = 34;
   localparam int MUL_W    = 33;
   localparam int PROD_W   = 64;
   localparam int IDX_W    = 12;
   localparam int CNT_W    = 16;
   localparam int CH_W     = 8;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int QBITS    = 18;
   localparam int STEP_W   = 5;
   localparam int REM_W    = 54;

   localparam logic signed [Z_W-1:0] Z_TWO = Z_W'(64'sd2 <<< FRAC_W);
   localparam logic signed [PROD_W-1:0] SUM_FOUR = PROD_W'(64'sd4 <<< (2 * FRAC_W));

   localparam logic signed [MUL_W-1:0] RED_NUM   = MUL_W'(100000);
   localparam logic signed [MUL_W-1:0] RED_DEN   = MUL_W'(1394 * 215);
   localparam logic signed [MUL_W-1:0] GREEN_NUM = MUL_W'(1000000);
   localparam logic signed [MUL_W-1:0] GREEN_DEN = MUL_W'(1548 * 220);
   localparam logic signed [MUL_W-1:0] BLUE_NUM  = MUL_W'(460);
   localparam logic signed [MUL_W-1:0] BLUE_DEN  = MUL_W'(255);

   localparam logic [31:0] X_ORIGIN_RST = 32'hF800_0000;
   localparam logic [31:0] Y_ORIGIN_RST = 32'hF800_0000;
   localparam logic [31:0] X_INC_RST    = 32'd1073741;
   localparam logic [31:0] Y_INC_RST    = 32'd1073741;
   localparam logic [15:0] LIMIT_RST    = 16'd1000;

   typedef enum logic [2:0] {
      REG_X_ORIGIN = 3'd0,
      REG_Y_ORIGIN = 3'd1,
      REG_X_INC    = 3'd2,
      REG_Y_INC    = 3'd3,
      REG_LIMIT    = 3'd4
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MAP_X,
      ST_MAP_Y,
      ST_MAP_C,
      ST_ITER_CHK,
      ST_ITER_II,
      ST_ITER_RI,
      ST_ITER_UPD,
      ST_COL_NN,
      ST_COL_SQ,
      ST_COL_NUM,
      ST_COL_DEN,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE
   } chan_type;

endpackage

@@ rtl/mebp_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on mebp_pkg for operand and product widths.
module mebp_mul (
   input  logic                                    clock,
   input  logic signed [mebp_pkg::MUL_W-1:0]       mul_a,
   input  logic signed [mebp_pkg::MUL_W-1:0]       mul_b,
   output logic signed [mebp_pkg::PROD_W-1:0]      product_ff
);
   import mebp_pkg::*;

   logic signed [2*MUL_W-1:0] product_in;

   assign product_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in[PROD_W-1:0];
   end

endmodule

@@ rtl/mandelbrot_escape_pixel_unit.sv @@
// Escape-time pixel unit: maps a pixel to a point, iterates z = z*z + c on one
// shared multiplier, then derives the three colour channels with a serial divider.
// Iterations end at the limit, at the bound test or at the magnitude test, and
// each division runs 18 steps.
// One word is in flight at a time; a new word is taken in the cycle after the result
// is loaded. Synchronous reset clears the sequencer and output valid and loads the register defaults.
module mandelbrot_escape_pixel_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [11:0]                       req_column,
   input  logic [11:0]                       req_row,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [15:0]                       rsp_iteration_count,
   output logic [7:0]                        rsp_red,
   output logic [7:0]                        rsp_green,
   output logic [7:0]                        rsp_blue,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mebp_pkg::ADDR_W-1:0]       paddr,
   input  logic [mebp_pkg::DATA_W-1:0]       pwdata,
   output logic [mebp_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);
   import mebp_pkg::*;

   state_type state_ff, state_in;
   chan_type  chan_ff, chan_in;

   logic [31:0] x_origin_ff, y_origin_ff, x_inc_ff, y_inc_ff;
   logic [15:0] limit_ff;
   reg_index_type reg_sel;
   logic wr_en;

   logic [IDX_W-1:0] col_ff, row_ff;
   logic signed [COORD_W-1:0] cre_ff, cre_in, cim_ff, cim_in;
   logic signed [Z_W-1:0] re_ff, re_in, im_ff, im_in;
   logic signed [PROD_W-1:0] rr_ff, ii_ff, diff, twice, sum;
   logic signed [PROD_W-1:0] nre, nim;
   logic [CNT_W-1:0] n_ff;
   logic [31:0] nn_ff;
   logic [REM_W-1:0] rem_ff, dsh_ff;
   logic [CH_W-1:0] q_ff, q_in;
   logic [STEP_W-1:0] step_ff;
   logic [CH_W-1:0] red_ff, green_ff, blue_ff;
   logic ge;
   logic in_bounds, escaped;

   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] product;

   logic rsp_valid_ff;
   logic [CNT_W-1:0] rsp_cnt_ff;
   logic [CH_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic rsp_load;

   mebp_mul u_mul (
      .clock      (clock),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .product_ff (product)
   );

   // Register port.
   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en   = psel & penable & pwrite;

   always_comb begin
      unique case (reg_sel)
         REG_X_ORIGIN: prdata = x_origin_ff;
         REG_Y_ORIGIN: prdata = y_origin_ff;
         REG_X_INC:    prdata = x_inc_ff;
         REG_Y_INC:    prdata = y_inc_ff;
         REG_LIMIT:    prdata = {16'd0, limit_ff};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_origin_ff <= X_ORIGIN_RST;
         y_origin_ff <= Y_ORIGIN_RST;
         x_inc_ff    <= X_INC_RST;
         y_inc_ff    <= Y_INC_RST;
         limit_ff    <= LIMIT_RST;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_X_ORIGIN: x_origin_ff <= pwdata;
            REG_Y_ORIGIN: y_origin_ff <= pwdata;
            REG_X_INC:    x_inc_ff    <= pwdata;
            REG_Y_INC:    y_inc_ff    <= pwdata;
            REG_LIMIT:    limit_ff    <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Datapath helpers.
   assign in_bounds = (re_ff <= Z_TWO) && (re_ff >= -Z_TWO) &&
                      (im_ff <= Z_TWO) && (im_ff >= -Z_TWO);
   assign sum     = rr_ff + ii_ff;
   assign escaped = sum > SUM_FOUR;
   assign diff    = rr_ff - ii_ff;
   assign twice   = product <<< 1;
   assign nre     = diff >>> FRAC_W;
   assign nim     = twice >>> FRAC_W;
   assign re_in   = nre[Z_W-1:0] + Z_W'(cre_ff);
   assign im_in   = nim[Z_W-1:0] + Z_W'(cim_ff);
   assign cre_in  = x_origin_ff + product[COORD_W-1:0];
   assign cim_in  = y_origin_ff + product[COORD_W-1:0];
   assign ge      = rem_ff >= dsh_ff;
   assign q_in    = {q_ff[CH_W-2:0], ge};
   assign rsp_load = !rsp_valid_ff || !rsp_stall;

   // Multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MAP_X: begin
            mul_a = MUL_W'(col_ff);
            mul_b = MUL_W'($signed(x_inc_ff));
         end
         ST_MAP_Y: begin
            mul_a = MUL_W'(row_ff);
            mul_b = MUL_W'($signed(y_inc_ff));
         end
         ST_ITER_CHK: begin
            mul_a = re_ff[MUL_W-1:0];
            mul_b = re_ff[MUL_W-1:0];
         end
         ST_ITER_II: begin
            mul_a = im_ff[MUL_W-1:0];
            mul_b = im_ff[MUL_W-1:0];
         end
         ST_ITER_RI: begin
            mul_a = re_ff[MUL_W-1:0];
            mul_b = im_ff[MUL_W-1:0];
         end
         ST_COL_NN: begin
            mul_a = MUL_W'(n_ff);
            mul_b = MUL_W'(n_ff);
         end
         ST_COL_NUM: begin
            case (chan_ff)
               CH_RED: begin
                  mul_a = MUL_W'(nn_ff);
                  mul_b = RED_NUM;
               end
               CH_GREEN: begin
                  mul_a = MUL_W'(nn_ff);
                  mul_b = GREEN_NUM;
               end
               default: begin
                  mul_a = MUL_W'(n_ff);
                  mul_b = BLUE_NUM;
               end
            endcase
         end
         ST_COL_DEN: begin
            case (chan_ff)
               CH_RED: begin
                  mul_a = MUL_W'(limit_ff);
                  mul_b = RED_DEN;
               end
               CH_GREEN: begin
                  mul_a = MUL_W'(limit_ff);
                  mul_b = GREEN_DEN;
               end
               default: begin
                  mul_a = BLUE_DEN;
                  mul_b = MUL_W'(1);
               end
            endcase
         end
         default: ;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_MAP_X;
         ST_MAP_X:    state_in = ST_MAP_Y;
         ST_MAP_Y:    state_in = ST_MAP_C;
         ST_MAP_C:    state_in = ST_ITER_CHK;
         ST_ITER_CHK: begin
            if (n_ff >= limit_ff || !in_bounds) state_in = ST_COL_NN;
            else state_in = ST_ITER_II;
         end
         ST_ITER_II:  state_in = ST_ITER_RI;
         ST_ITER_RI:  state_in = ST_ITER_UPD;
         ST_ITER_UPD: begin
            if (escaped) state_in = ST_COL_NN;
            else state_in = ST_ITER_CHK;
         end
         ST_COL_NN:   state_in = ST_COL_SQ;
         ST_COL_SQ: begin
            state_in = ST_COL_NUM;
            chan_in  = CH_RED;
         end
         ST_COL_NUM:  state_in = ST_COL_DEN;
         ST_COL_DEN:  state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (step_ff == '0) begin
               case (chan_ff)
                  CH_RED: begin
                     chan_in  = CH_GREEN;
                     state_in = ST_COL_NUM;
                  end
                  CH_GREEN: begin
                     chan_in  = CH_BLUE;
                     state_in = ST_COL_NUM;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_DONE:     if (rsp_load) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= CH_RED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         if (state_ff == ST_DONE && rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            col_ff <= req_column;
            row_ff <= req_row;
         end
         ST_MAP_Y: cre_ff <= cre_in;
         ST_MAP_C: begin
            cim_ff <= cim_in;
            re_ff  <= Z_W'(cre_ff);
            im_ff  <= Z_W'(cim_in);
            n_ff   <= '0;
         end
         ST_ITER_II: rr_ff <= product;
         ST_ITER_RI: ii_ff <= product;
         ST_ITER_UPD: begin
            if (!escaped) begin
               re_ff <= re_in;
               im_ff <= im_in;
               n_ff  <= n_ff + 1'b1;
            end
         end
         ST_COL_SQ:  nn_ff <= product[31:0];
         ST_COL_DEN: rem_ff <= product[REM_W-1:0];
         ST_DIV_LOAD: begin
            dsh_ff  <= {product[REM_W-QBITS:0], {(QBITS-1){1'b0}}};
            step_ff <= STEP_W'(QBITS - 1);
            q_ff    <= '0;
         end
         ST_DIV_RUN: begin
            if (ge) rem_ff <= rem_ff - dsh_ff;
            dsh_ff  <= dsh_ff >> 1;
            q_ff    <= q_in;
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               case (chan_ff)
                  CH_RED:   red_ff   <= (limit_ff == '0) ? '0 : q_in;
                  CH_GREEN: green_ff <= (limit_ff == '0) ? '0 : q_in;
                  default:  blue_ff  <= q_in;
               endcase
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_cnt_ff   <= n_ff;
               rsp_red_ff   <= red_ff;
               rsp_green_ff <= green_ff;
               rsp_blue_ff  <= blue_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_cnt_ff;
   assign rsp_red             = rsp_red_ff;
   assign rsp_green           = rsp_green_ff;
   assign rsp_blue            = rsp_blue_ff;

   a_count_in_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER_II || state_ff == ST_ITER_RI || state_ff == ST_ITER_UPD)
      |-> (n_ff < limit_ff))
      else $error("iteration count passed the limit");

   a_square_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER_II) |-> (re_ff <= Z_TWO && re_ff >= -Z_TWO &&
                                    im_ff <= Z_TWO && im_ff >= -Z_TWO))
      else $error("squaring an operand outside the escape radius");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_LOAD) |=> (state_ff == ST_DIV_RUN &&
                                     step_ff == STEP_W'(QBITS - 1)))
      else $error("divider did not start with a full step count");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_DONE))
      else $error("finished word dropped while output was stalled");

endmodule
